FILE: src/eap_pkg.sv
// Shared types and codes for the attribute stream parser.
`default_nettype none

package eap_pkg;

    // Parse phase within the byte stream
    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2,
        PH_ERROR = 2'd3
    } phase_t;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result record kinds
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_ZERO_LEN  = 2'd1;
    localparam logic [1:0] ERR_TRUNC_HDR = 2'd2;
    localparam logic [1:0] ERR_TRUNC_VAL = 2'd3;

    // Length word is in units of four bytes and counts the type and length bytes
    localparam logic [9:0] HEADER_BYTES = 10'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] record_kind;
        logic [7:0] attr_type;
        logic [7:0] value_byte;
        logic [9:0] value_index;
        logic       value_last;
        logic [9:0] value_length;
        logic [1:0] error_code;
    } out_item_t;

    // Parser state carried between items
    typedef struct packed {
        phase_t     phase;
        logic [7:0] current_type;
        logic [9:0] bytes_left;
        logic [9:0] byte_position;
        logic [9:0] total_value_length;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:              PH_TYPE,
        current_type:       8'd0,
        bytes_left:         10'd0,
        byte_position:      10'd0,
        total_value_length: 10'd0
    };

endpackage

`default_nettype wire

FILE: src/eap_in_if.sv
// Input channel of the attribute stream parser: one buffer byte or end mark per item.
`default_nettype none

interface eap_in_if;
    import eap_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: src/eap_out_if.sv
// Result channel of the attribute stream parser: one record per item.
`default_nettype none

interface eap_out_if;
    import eap_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: src/eap_parse_core.sv
// Next-state and result logic for one input item of the attribute parser.
`default_nettype none

module eap_parse_core (
    input  eap_pkg::parse_state_t state,
    input  eap_pkg::in_item_t     item,
    output eap_pkg::parse_state_t state_next,
    output logic                  emit,
    output eap_pkg::out_item_t    result
);
    import eap_pkg::*;

    logic [9:0] length_bytes;
    logic       value_last;

    // Value length from the length word: words times four, minus the header
    assign length_bytes = {item.data_byte, 2'b00} - HEADER_BYTES;
    assign value_last   = (state.bytes_left == 10'd1);

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        result     = '0;

        if (item.opcode == OP_END)
        begin
            // Report how the buffer ended, then return to reset state
            emit       = 1'b1;
            state_next = PARSE_STATE_RESET;
            unique case (state.phase)
                PH_TYPE:
                begin
                    result.record_kind = KIND_DONE;
                end
                PH_LEN:
                begin
                    result.record_kind = KIND_ERROR;
                    result.attr_type   = state.current_type;
                    result.error_code  = ERR_TRUNC_HDR;
                end
                PH_VALUE:
                begin
                    result.record_kind  = KIND_ERROR;
                    result.attr_type    = state.current_type;
                    result.value_length = state.total_value_length;
                    result.error_code   = ERR_TRUNC_VAL;
                end
                default:
                begin
                    result.record_kind = KIND_ERROR;
                    result.attr_type   = state.current_type;
                    result.error_code  = ERR_ZERO_LEN;
                end
            endcase
        end
        else
        begin
            unique case (state.phase)
                PH_TYPE:
                begin
                    // Hold the type byte
                    state_next.current_type = item.data_byte;
                    state_next.phase        = PH_LEN;
                end
                PH_LEN:
                begin
                    if (item.data_byte == 8'd0)
                    begin
                        // Flag a zero length now; drop bytes until end of buffer
                        state_next.phase   = PH_ERROR;
                        emit               = 1'b1;
                        result.record_kind = KIND_ERROR;
                        result.attr_type   = state.current_type;
                        result.error_code  = ERR_ZERO_LEN;
                    end
                    else
                    begin
                        state_next.total_value_length = length_bytes;
                        state_next.bytes_left         = length_bytes;
                        state_next.byte_position      = 10'd0;
                        state_next.phase              = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    // Emit the value byte and advance the counters
                    emit                = 1'b1;
                    result.record_kind  = KIND_VALUE;
                    result.attr_type    = state.current_type;
                    result.value_byte   = item.data_byte;
                    result.value_index  = state.byte_position;
                    result.value_last   = value_last;
                    result.value_length = state.total_value_length;
                    result.error_code   = ERR_NONE;
                    if (value_last)
                    begin
                        state_next.phase         = PH_TYPE;
                        state_next.bytes_left    = 10'd0;
                        state_next.byte_position = 10'd0;
                    end
                    else
                    begin
                        state_next.bytes_left    = state.bytes_left - 10'd1;
                        state_next.byte_position = state.byte_position + 10'd1;
                    end
                end
                default:
                begin
                    // Error phase: ignore data bytes
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/eap_attribute_stream_parser.sv
// Top level of the streaming type-length-value attribute parser.
//
// Takes one buffer byte (or an end-of-buffer mark) per item and returns at
// most one record per item: each value byte with its attribute type, index,
// value length and last flag; an error record as soon as a zero length word
// is seen; and on end of buffer a clean-end or truncation record, after which
// the parser is back in its reset state. The block sustains one byte per
// cycle while the output side keeps taking records; a record appears in the
// output register the cycle after its item is accepted. The parse core
// computes the next state combinationally from each item. The input is taken
// whenever the output register is empty or being emptied in the same cycle.
`default_nettype none

module eap_attribute_stream_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    eap_in_if.sink     in_items,
    eap_out_if.source  out_items
);
    import eap_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    out_item_t    out_item_reg;
    logic         emit;
    out_item_t    result;
    logic         in_accept;

    // Accept while the result register is free or draining this cycle
    assign in_items.ready = !out_valid_reg || out_items.ready;
    assign in_accept      = in_items.valid && in_items.ready;

    eap_parse_core u_core (
        .state      (state_reg),
        .item       (in_items.item),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    // Advance parser state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_STATE_RESET;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_items.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            out_item_reg <= result;
        end
    end

    assign out_items.valid = out_valid_reg;
    assign out_items.item  = out_item_reg;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the streaming attribute parser.
`timescale 1ns / 100ps

import eap_pkg::*;

// Predicts parser records from accepted items and checks the records that come out
class attr_record_scoreboard;
    out_item_t  pending_records[$];
    int         mismatches;
    int         parsed_items;
    phase_t     cur_phase;
    logic [7:0] cur_type;
    logic [9:0] bytes_left;
    logic [9:0] byte_pos;
    logic [9:0] total_len;
    bit         zero_len_seen;

    function void clear_parse();
        cur_phase     = PH_TYPE;
        cur_type      = 8'd0;
        bytes_left    = 10'd0;
        byte_pos      = 10'd0;
        total_len     = 10'd0;
        zero_len_seen = 1'b0;
    endfunction

    // Advance the parse by one accepted item and queue the record it causes
    function void note_item(in_item_t it);
        out_item_t rec;
        rec = '0;
        parsed_items++;
        if (it.opcode == OP_END) begin
            rec.record_kind = KIND_ERROR;
            rec.attr_type   = cur_type;
            if (zero_len_seen || cur_phase == PH_ERROR) begin
                rec.error_code = ERR_ZERO_LEN;
            end
            else if (cur_phase == PH_TYPE) begin
                rec.record_kind = KIND_DONE;
                rec.attr_type   = 8'd0;
            end
            else if (cur_phase == PH_LEN) begin
                rec.error_code = ERR_TRUNC_HDR;
            end
            else begin
                rec.error_code   = ERR_TRUNC_VAL;
                rec.value_length = total_len;
            end
            pending_records.push_back(rec);
            clear_parse();
            return;
        end
        case (cur_phase)
            PH_TYPE:
            begin
                cur_type  = it.data_byte;
                cur_phase = PH_LEN;
            end
            PH_LEN:
            begin
                if (it.data_byte == 8'd0) begin
                    zero_len_seen   = 1'b1;
                    cur_phase       = PH_ERROR;
                    rec.record_kind = KIND_ERROR;
                    rec.attr_type   = cur_type;
                    rec.error_code  = ERR_ZERO_LEN;
                    pending_records.push_back(rec);
                end
                else begin
                    total_len  = ({2'b00, it.data_byte} << 2) - HEADER_BYTES;
                    bytes_left = total_len;
                    byte_pos   = 10'd0;
                    cur_phase  = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                rec.record_kind  = KIND_VALUE;
                rec.attr_type    = cur_type;
                rec.value_byte   = it.data_byte;
                rec.value_index  = byte_pos;
                rec.value_last   = (bytes_left == 10'd1);
                rec.value_length = total_len;
                rec.error_code   = ERR_NONE;
                pending_records.push_back(rec);
                bytes_left = bytes_left - 10'd1;
                byte_pos   = byte_pos + 10'd1;
                if (rec.value_last) begin
                    cur_phase  = PH_TYPE;
                    bytes_left = 10'd0;
                    byte_pos   = 10'd0;
                end
            end
            default:
            begin
                // bytes after a zero length are dropped by the parser
                parsed_items--;
            end
        endcase
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare one accepted record with the oldest prediction
    function void check_record(out_item_t got);
        out_item_t want;
        if (pending_records.size() == 0) begin
            $display("%0t: unexpected record, expected none, got %h", $time, got);
            mismatches++;
            return;
        end
        want = pending_records.pop_front();
        check_field("record_kind", want.record_kind, got.record_kind);
        check_field("attr_type", want.attr_type, got.attr_type);
        check_field("value_byte", want.value_byte, got.value_byte);
        check_field("value_index", want.value_index, got.value_index);
        check_field("value_last", want.value_last, got.value_last);
        check_field("value_length", want.value_length, got.value_length);
        check_field("error_code", want.error_code, got.error_code);
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   sink_hold;

    attr_record_scoreboard board;

    eap_in_if  in_if();
    eap_out_if out_if();

    eap_attribute_stream_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_items  (in_if),
        .out_items (out_if)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Take records, check them, and pick ready for the next cycle
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                board.check_record(out_if.item);
            if (sink_hold > 0) begin
                sink_hold--;
                out_if.ready <= 1'b0;
            end
            else begin
                out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one item, idling first at random, and hold it until accepted
    task automatic send_item(input logic op, input logic [7:0] data);
        in_item_t it;
        it.opcode    = op;
        it.data_byte = data;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.item  <= it;
        @(posedge clk);
        while (in_if.ready !== 1'b1)
            @(posedge clk);
        board.note_item(it);
    endtask

    task automatic send_end();
        send_item(OP_END, 8'($urandom_range(255)));
    endtask

    task automatic send_random_bytes(input int count);
        for (int i = 0; i < count; i++)
            send_item(OP_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic send_attribute(input logic [7:0] attr, input logic [7:0] words,
                                  input int value_bytes);
        send_item(OP_BYTE, attr);
        send_item(OP_BYTE, words);
        send_random_bytes(value_bytes);
    endtask

    // Hold the input idle until every predicted record has been taken
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_records.size() != 0)
            @(posedge clk);
    endtask

    // One buffer: mostly well-formed attributes, then a clean or broken ending
    task automatic send_random_buffer();
        int         n_attr;
        int         ending;
        int         full_len;
        logic [7:0] words;
        n_attr = $urandom_range(3);
        ending = $urandom_range(99);
        for (int a = 0; a < n_attr; a++) begin
            if ($urandom_range(149) == 0)
                words = 8'd255;
            else if ($urandom_range(19) == 0)
                words = 8'($urandom_range(40, 5));
            else
                words = 8'($urandom_range(4, 1));
            send_attribute(8'($urandom_range(255)), words, words * 4 - 2);
        end
        if (ending < 78 && ending >= 70) begin
            send_item(OP_BYTE, 8'($urandom_range(255)));
        end
        else if (ending < 88 && ending >= 78) begin
            words    = 8'($urandom_range(6, 1));
            full_len = words * 4 - 2;
            send_attribute(8'($urandom_range(255)), words, $urandom_range(full_len - 1));
        end
        else if (ending < 95 && ending >= 88) begin
            send_attribute(8'($urandom_range(255)), 8'd0, 0);
            send_random_bytes($urandom_range(5));
        end
        else if (ending >= 95) begin
            send_random_bytes($urandom_range(8, 1));
        end
        send_end();
    endtask

    initial begin
        board = new();
        board.clear_parse();
        src_idle_pct  = 25;
        sink_idle_pct = 25;
        sink_hold     = 0;
        rst_n       <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.item  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty buffer, end mark with data bits set
        send_item(OP_END, 8'h00);
        send_item(OP_END, 8'hFF);
        // Shortest attribute with extreme type and value bytes, clean end
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_end();
        // Zero length word, trailing bytes dropped, error repeated at end
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h01);
        send_end();
        // Buffer cut after the type byte
        send_item(OP_BYTE, 8'hA5);
        send_end();
        // Buffer cut inside a value
        send_attribute(8'h5A, 8'h02, 3);
        send_end();
        // Large length cut after one value byte
        send_attribute(8'h3C, 8'h80, 1);
        send_end();
        wait_drained();

        // Longest attribute, every index reached
        send_attribute(8'hC3, 8'd255, 1018);
        send_end();

        // Random, both sides idling
        while (board.parsed_items < ITEM_TARGET / 3)
            send_random_buffer();

        // Stall the receiver while items keep coming, then let it all drain
        sink_hold = 300;
        repeat (4) send_random_buffer();
        wait_drained();

        // Stretch with no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (board.parsed_items < (ITEM_TARGET * 2) / 3)
            send_random_buffer();

        src_idle_pct  = 25;
        sink_idle_pct = 25;
        while (board.parsed_items < ITEM_TARGET)
            send_random_buffer();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_records.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: eap_attribute_stream_parser.f
src/eap_pkg.sv
src/eap_in_if.sv
src/eap_out_if.sv
src/eap_parse_core.sv
src/eap_attribute_stream_parser.sv
dv/testbench.sv
